/* design/hrs_pkg.sv */
// Package for the homography reprojection scorer: widths, register indexes and
// the pair and score structs. Used by every module of the block.
`timescale 1ns / 1ps
package hrs_pkg;

	localparam int MAX_PAIRS   = 4096;
	localparam int COORD_BITS  = 14;
	localparam int CNT_W       = 13;
	localparam int SUM_W       = 36;
	localparam int DIST_W      = 24;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
	localparam logic [26:0]       QUOT_LIMIT = 27'd67108864;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0   = 3'd0,
		REG_ROW1   = 3'd1,
		REG_SHIFT  = 3'd2,
		REG_PERSP  = 3'd3,
		REG_INLIER = 3'd4,
		REG_CAP    = 3'd5,
		REG_RATIO  = 3'd6,
		REG_CHECK  = 3'd7
	} reg_idx_t;

	// One item handed from the front part to the back part.
	typedef struct packed {
		logic [COORD_BITS-1:0] src_x;
		logic [COORD_BITS-1:0] src_y;
		logic [COORD_BITS-1:0] dst_x;
		logic [COORD_BITS-1:0] dst_y;
		logic                  last;
	} pair_t;

	// Per-pair outcome handed from the back part to the accumulator.
	typedef struct packed {
		logic [DIST_W-1:0] dist_val;
		logic              inlier;
		logic              last;
	} score_t;

endpackage

/* design/hrs_if.sv */
// Valid/ready channel interface, generic over payload type.
// Depends on nothing.
`timescale 1ns / 1ps
interface hrs_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* design/hrs_queue.sv */
// Two-entry queue between front and back parts.
// Depends on hrs_pkg.
`timescale 1ns / 1ps
module hrs_queue import hrs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  pair_t push_data,
	output logic  full,
	input  logic  pop,
	output pair_t pop_data,
	output logic  empty
);
	pair_t    mem_q [QUEUE_DEPTH];
	logic     wptr_q, rptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'(QUEUE_DEPTH));
	assign empty    = (count_q == 2'd0);
	assign pop_data = mem_q[rptr_q];

	// Storage writes.
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wptr_q] <= push_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push && !full) wptr_q <= ~wptr_q;
			if (pop && !empty) rptr_q <= ~rptr_q;
			count_q <= count_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= 2'(QUEUE_DEPTH))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !(pop && !empty)) |=> !empty)
		else $error("queue lost a push");
	assert property (@(posedge clk) disable iff (!arst_n) full |-> !empty)
		else $error("queue full and empty");
endmodule

/* design/hrs_project.sv */
// Back part: projects one pair through H and computes the clamped distance.
// Multiplies over several steps, a restoring divider for x and y, an isqrt.
// Depends on hrs_pkg.
`timescale 1ns / 1ps
module hrs_project import hrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CFG_W-1:0]  row0,
	input  logic [CFG_W-1:0]  row1,
	input  logic [CFG_W-1:0]  shift,
	input  logic [CFG_W-1:0]  persp,
	input  logic [DIST_W-1:0] inlier_thr,
	input  logic              start,
	input  pair_t             pair,
	output logic              busy,
	output logic              done,
	output score_t            score
);
	typedef enum logic [3:0] {
		S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_MUL5, S_ZCHK,
		S_DIVX, S_DIVY, S_DIFF, S_SQ, S_SQRT, S_FIN
	} state_t;

	// Step count at which a quotient is complete: setup, then 26 quotient bits.
	localparam logic [4:0] DIV_LAST = 5'd27;

	state_t state_q;
	logic [COORD_BITS-1:0] x_q, y_q, ux_q, uy_q;
	logic last_q;
	logic signed [63:0] acc_q;      // running sum for one product chain
	logic signed [63:0] z_q, nx_q, ny_q;
	logic signed [63:0] px_q, py_q;
	// Divider state
	logic [63:0] dr_q;              // remainder
	logic [26:0] dq_q;              // quotient
	logic [4:0]  dstep_q;
	logic        dneg_q;
	// Distance
	logic [27:0] adx_q, ady_q;
	logic [55:0] sq_q;
	logic [55:0] sres_q, sbit_q;
	logic [DIST_W-1:0] dist_q;

	logic signed [31:0] ca, cb, cc, cd, ce, cf, cg, ch;
	assign ca = row0[63:32];  assign cb = row0[31:0];
	assign cd = row1[63:32];  assign ce = row1[31:0];
	assign cc = shift[63:32]; assign cf = shift[31:0];
	assign cg = persp[63:32]; assign ch = persp[31:0];

	// One coefficient times one coordinate per step.
	logic signed [31:0] mul_c;
	logic [COORD_BITS-1:0] mul_v;
	logic signed [63:0] prod;
	always_comb begin
		unique case (state_q)
			S_MUL0:  begin mul_c = cg; mul_v = x_q; end
			S_MUL1:  begin mul_c = ch; mul_v = y_q; end
			S_MUL2:  begin mul_c = ca; mul_v = x_q; end
			S_MUL3:  begin mul_c = cb; mul_v = y_q; end
			S_MUL4:  begin mul_c = cd; mul_v = x_q; end
			S_MUL5:  begin mul_c = ce; mul_v = y_q; end
			default: begin mul_c = '0; mul_v = '0; end
		endcase
		prod = 64'(mul_c) * 64'($signed({1'b0, mul_v}));
	end

	// Divider setup: magnitude, divisor scaled by 16 and fast saturation check.
	logic signed [63:0] num_sel;
	logic [63:0] num_mag, z_u, z16;
	logic        num_neg, big;
	always_comb begin
		num_sel = (state_q == S_DIVY) ? ny_q : nx_q;
		num_neg = num_sel[63];
		num_mag = num_neg ? 64'(-num_sel) : 64'(num_sel);
		z_u     = 64'(z_q);
		z16     = {z_u[59:0], 4'b0};
		big     = num_mag >= z16;
	end

	// Restoring division step against 16*z: remainder shifted left, one bit.
	logic [64:0] r_sh;
	logic        r_ge;
	always_comb begin
		r_sh = {dr_q, 1'b0};
		r_ge = r_sh >= {1'b0, z16};
	end

	// isqrt step.
	logic [55:0] s_try;
	assign s_try = sres_q + sbit_q;

	// Signed differences for the distance stage.
	logic signed [28:0] dx, dy;
	always_comb begin
		dx = 29'(px_q) - $signed({1'b0, 28'({ux_q, 8'd0})});
		dy = 29'(py_q) - $signed({1'b0, 28'({uy_q, 8'd0})});
	end

	logic signed [63:0] quot_s;
	always_comb begin
		quot_s = dneg_q ? -64'(dq_q) : 64'(dq_q);
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
			dstep_q <= 5'd0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					x_q <= pair.src_x; y_q <= pair.src_y;
					ux_q <= pair.dst_x; uy_q <= pair.dst_y;
					last_q <= pair.last;
					acc_q <= 64'sd1 <<< 30;
					state_q <= S_MUL0;
				end
				S_MUL0: begin acc_q <= acc_q + prod; state_q <= S_MUL1; end
				S_MUL1: begin
					z_q <= acc_q + prod;
					acc_q <= 64'(cc) <<< 0;
					state_q <= S_MUL2;
				end
				S_MUL2: begin acc_q <= acc_q + prod; state_q <= S_MUL3; end
				S_MUL3: begin
					nx_q <= acc_q + prod;
					acc_q <= 64'(cf);
					state_q <= S_MUL4;
				end
				S_MUL4: begin acc_q <= acc_q + prod; state_q <= S_MUL5; end
				S_MUL5: begin ny_q <= acc_q + prod; state_q <= S_ZCHK; end
				S_ZCHK: begin
					// Non-positive divisor: saturated outlier.
					if (z_q <= 0) begin
						dist_q  <= DIST_MAX;
						state_q <= S_FIN;
					end else begin
						dstep_q <= 5'd0;
						state_q <= S_DIVX;
					end
				end
				S_DIVX, S_DIVY: begin
					if (dstep_q == 5'd0) begin
						// The numerator is below 16*z here, so dividing by 16*z
						// over 26 steps yields the Q.8 quotient directly.
						dneg_q <= num_neg;
						if (big) begin
							dq_q <= QUOT_LIMIT;
							dstep_q <= DIV_LAST;
						end else begin
							dq_q <= '0;
							dr_q <= num_mag;
							dstep_q <= 5'd1;
						end
					end else if (dstep_q != DIV_LAST) begin
						dq_q <= {dq_q[25:0], r_ge};
						dr_q <= r_ge ? 64'(r_sh - {1'b0, z16}) : r_sh[63:0];
						dstep_q <= dstep_q + 5'd1;
					end else begin
						if (dq_q > QUOT_LIMIT) dq_q <= QUOT_LIMIT;
						dstep_q <= 5'd0;
						if (state_q == S_DIVX) begin
							px_q <= (dq_q > QUOT_LIMIT) ?
								(dneg_q ? -64'(QUOT_LIMIT) : 64'(QUOT_LIMIT)) : quot_s;
							state_q <= S_DIVY;
						end else begin
							py_q <= (dq_q > QUOT_LIMIT) ?
								(dneg_q ? -64'(QUOT_LIMIT) : 64'(QUOT_LIMIT)) : quot_s;
							state_q <= S_DIFF;
						end
					end
				end
				S_DIFF: begin
					adx_q <= dx[28] ? 28'(-dx) : 28'(dx);
					ady_q <= dy[28] ? 28'(-dy) : 28'(dy);
					state_q <= S_SQ;
				end
				S_SQ: begin
					sq_q  <= 56'(adx_q) * 56'(adx_q) + 56'(ady_q) * 56'(ady_q);
					sres_q <= '0;
					sbit_q <= 56'd1 << 54;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (sbit_q == '0) begin
						dist_q <= (sres_q > 56'(DIST_MAX)) ? DIST_MAX : DIST_W'(sres_q);
						state_q <= S_FIN;
					end else begin
						if (sq_q >= s_try) begin
							sq_q  <= sq_q - s_try;
							sres_q <= (sres_q >> 1) + sbit_q;
						end else begin
							sres_q <= sres_q >> 1;
						end
						sbit_q <= sbit_q >> 2;
					end
				end
				S_FIN: begin
					score.dist_val <= dist_q;
					score.inlier   <= (z_q > 0) && (dist_q <= inlier_thr);
					score.last     <= last_q;
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(state_q) == S_FIN)
		else $error("done without finish");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> state_q == S_MUL0)
		else $error("start not taken");
	assert property (@(posedge clk) disable iff (!arst_n) dstep_q <= DIV_LAST)
		else $error("divider step out of range");
endmodule

/* design/homography_reprojection_scorer.sv */
// Top level of the homography reprojection scorer: config registers, front part,
// queue, back part, set accumulator. Uses hrs_pkg, hrs_if, hrs_queue, hrs_project.
//
// Usage:
//  in  channel (sink):   one correspondence beat {src_x, src_y, dst_x, dst_y, last}.
//  out channel (source): one totals beat per set, sent on the beat marked last.
//  Configuration: write enable cfg_we, index cfg_idx, data cfg_data; write only
//  while the block is idle.
// Sequence: the back end takes one pair at a time through start, six multiply
//  steps, divisor check, two quotient loops, two distance steps, a square root
//  loop, finish and the accumulate step. A clamped quotient skips its loop; a
//  non-positive divisor ends a pair at the divisor check, going to finish.
// The totals beat is registered once the last pair of a set is accumulated;
//  the queue takes new pairs while the back end works, but the next pair
//  starts only after a pending totals beat is taken.
// Reset: asynchronous, active low; restores the register defaults and clears
//  the running totals, any pending totals beat and the queue.
// A stalled receiver holds the totals beat in the output register; the back
//  end then waits, the queue fills and in.ready drops.
`timescale 1ns / 1ps
module homography_reprojection_scorer import hrs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	hrs_if.sink                  in,
	hrs_if.source                out
);
	logic [CFG_W-1:0] row0_q, row1_q, shift_q, persp_q;
	logic [DIST_W-1:0] inlier_q, cap_q;
	logic [16:0] ratio_q;
	logic check_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q <= 64'd281474976710656; row1_q <= 64'd65536;
			shift_q <= '0; persp_q <= '0;
			inlier_q <= 24'd768; cap_q <= 24'd768;
			ratio_q <= 17'd32768; check_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_ROW0:   row0_q   <= cfg_data;
				REG_ROW1:   row1_q   <= cfg_data;
				REG_SHIFT:  shift_q  <= cfg_data;
				REG_PERSP:  persp_q  <= cfg_data;
				REG_INLIER: inlier_q <= cfg_data[DIST_W-1:0];
				REG_CAP:    cap_q    <= cfg_data[DIST_W-1:0];
				REG_RATIO:  ratio_q  <= cfg_data[16:0];
				REG_CHECK:  check_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Front: accept into the queue.
	logic  q_full, q_empty, q_pop;
	pair_t q_out;
	assign in.ready = !q_full;
	hrs_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(in.valid), .push_data(in.data), .full(q_full),
		.pop(q_pop), .pop_data(q_out), .empty(q_empty)
	);

	// Back: project, then accumulate.
	logic   busy, done;
	score_t score;
	logic   out_valid_q;
	assign q_pop = !q_empty && !busy && !done && !out_valid_q;
	hrs_project u_proj (
		.clk(clk), .arst_n(arst_n),
		.row0(row0_q), .row1(row1_q), .shift(shift_q), .persp(persp_q),
		.inlier_thr(inlier_q), .start(q_pop), .pair(q_out),
		.busy(busy), .done(done), .score(score)
	);

	logic [CNT_W-1:0] pairs_q, inl_q, np, ni;
	logic [SUM_W-1:0] cost_q, dsum_q, nc, nd;
	logic [SUM_W:0] cs, ds;
	logic [DIST_W-1:0] capped;
	always_comb begin
		np = (pairs_q < CNT_W'(MAX_PAIRS)) ? pairs_q + 1'b1 : pairs_q;
		ni = (score.inlier && inl_q < CNT_W'(MAX_PAIRS)) ? inl_q + 1'b1 : inl_q;
		capped = (score.dist_val > cap_q) ? cap_q : score.dist_val;
		cs = {1'b0, cost_q} + (SUM_W+1)'(capped);
		ds = {1'b0, dsum_q} + (SUM_W+1)'(score.dist_val);
		nc = cs[SUM_W] ? SUM_MAX : cs[SUM_W-1:0];
		nd = ds[SUM_W] ? SUM_MAX : ds[SUM_W-1:0];
	end

	logic [29:0] lhs, rhs;
	assign lhs = {1'b0, ni, 16'd0};
	assign rhs = 30'(ratio_q) * 30'(np);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_q <= '0; inl_q <= '0; cost_q <= '0; dsum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out.valid && out.ready) out_valid_q <= 1'b0;
			if (done) begin
				if (score.last) begin
					out.data.pair_count     <= np;
					out.data.inlier_count   <= ni;
					out.data.truncated_cost <= nc;
					out.data.distance_sum   <= nd;
					out.data.too_few        <= np < CNT_W'(4);
					out.data.accepted       <= !(np < CNT_W'(4)) &&
						(!check_q || lhs[29:0] >= rhs);
					out_valid_q <= 1'b1;
					pairs_q <= '0; inl_q <= '0; cost_q <= '0; dsum_q <= '0;
				end else begin
					pairs_q <= np; inl_q <= ni; cost_q <= nc; dsum_q <= nd;
				end
			end
		end
	end
	assign out.valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !out_valid_q)
		else $error("result overwritten while pending");
	assert property (@(posedge clk) disable iff (!arst_n) pairs_q <= CNT_W'(MAX_PAIRS))
		else $error("pair count beyond saturation");
	assert property (@(posedge clk) disable iff (!arst_n) inl_q <= pairs_q)
		else $error("more inliers than pairs");
endmodule

/* test/hrs_tb_pkg.sv */
// Testbench types for the homography reprojection scorer: the totals beat layout.
// Depends on hrs_pkg.
`timescale 1ns / 1ps
package hrs_tb_pkg;
	import hrs_pkg::*;

	// One totals beat, fields in the order of the output list.
	typedef struct packed {
		logic [CNT_W-1:0] pair_count;
		logic [CNT_W-1:0] inlier_count;
		logic [SUM_W-1:0] truncated_cost;
		logic [SUM_W-1:0] distance_sum;
		logic             too_few;
		logic             accepted;
	} totals_t;

endpackage

/* test/hrs_scoreboard.sv */
// Checker for the homography reprojection scorer: mirrors the register writes,
// predicts the totals of each set and compares every output beat.
// Depends on hrs_pkg, hrs_tb_pkg and hrs_if.
`timescale 1ns / 1ps
module hrs_scoreboard import hrs_pkg::*, hrs_tb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	hrs_if                       in_mon,
	hrs_if                       out_mon,
	output int                   fail_count,
	output int                   pending
);
	localparam longint unsigned CLAMP_Q8 = 64'd67108864;

	logic [63:0]       row0, row1, shift, persp;
	logic [DIST_W-1:0] inlier_thr, cap;
	logic [16:0]       ratio;
	logic              check_on;

	logic [CNT_W-1:0] pairs_acc, inliers_acc;
	logic [SUM_W-1:0] cost_acc, dist_acc;
	totals_t          totals_q[$];

	assign pending = totals_q.size();

	// Projected coordinate num / den in Q.8, truncated toward zero and clamped.
	function automatic longint project_q8(longint num, longint den);
		longint unsigned mag, dd, q, r;
		bit neg;
		neg = num < 0;
		mag = neg ? -num : num;
		dd = den;
		if (mag >= dd * 16) begin
			q = CLAMP_Q8;
		end else begin
			q = mag / dd;
			r = mag % dd;
			for (int i = 0; i < 22; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= dd) begin
					r -= dd;
					q |= 1;
				end
			end
			if (q > CLAMP_Q8) q = CLAMP_Q8;
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// True when the projective divisor of the pair is positive.
	function automatic bit divisor_ok(pair_t p);
		longint x, y, g, h;
		x = p.src_x; y = p.src_y;
		g = $signed(persp[63:32]); h = $signed(persp[31:0]);
		return (g * x + h * y + (64'sd1 <<< 30)) > 0;
	endfunction

	// Saturated reprojection distance of one pair, Q16.8.
	function automatic logic [DIST_W-1:0] reproj_dist(pair_t p);
		longint x, y, ux, uy, a, b, c, d, e, f, g, h, z, dx, dy;
		longint unsigned adx, ady, root;
		x = p.src_x; y = p.src_y; ux = p.dst_x; uy = p.dst_y;
		a = $signed(row0[63:32]);  b = $signed(row0[31:0]);
		d = $signed(row1[63:32]);  e = $signed(row1[31:0]);
		c = $signed(shift[63:32]); f = $signed(shift[31:0]);
		g = $signed(persp[63:32]); h = $signed(persp[31:0]);
		z = g * x + h * y + (64'sd1 <<< 30);
		if (z <= 0) return DIST_MAX;
		dx = project_q8(a * x + b * y + c, z) - ux * 256;
		dy = project_q8(d * x + e * y + f, z) - uy * 256;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		root = int_sqrt(adx * adx + ady * ady);
		return root > DIST_MAX ? DIST_MAX : root[DIST_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] sum_sat(logic [SUM_W-1:0] acc,
			logic [DIST_W-1:0] add);
		logic [SUM_W:0] s;
		s = acc + add;
		return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
	endfunction

	// Register mirror, set accumulation and output comparison.
	always @(posedge clk or negedge arst_n) begin
		logic [DIST_W-1:0] pair_dist;
		logic              inl, few;
		totals_t           exp_t, got;
		if (!arst_n) begin
			row0 <= 64'h0001_0000_0000_0000;
			row1 <= 64'h0000_0000_0001_0000;
			shift <= '0;
			persp <= '0;
			inlier_thr <= 24'd768;
			cap <= 24'd768;
			ratio <= 17'd32768;
			check_on <= 1'b1;
			pairs_acc <= '0;
			inliers_acc <= '0;
			cost_acc <= '0;
			dist_acc <= '0;
			totals_q.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_ROW0:   row0 <= cfg_data;
					REG_ROW1:   row1 <= cfg_data;
					REG_SHIFT:  shift <= cfg_data;
					REG_PERSP:  persp <= cfg_data;
					REG_INLIER: inlier_thr <= cfg_data[DIST_W-1:0];
					REG_CAP:    cap <= cfg_data[DIST_W-1:0];
					REG_RATIO:  ratio <= cfg_data[16:0];
					REG_CHECK:  check_on <= cfg_data[0];
					default: ;
				endcase
			end
			// Score an accepted pair and close the set on its last beat.
			if (in_mon.valid && in_mon.ready) begin
				pair_dist = reproj_dist(in_mon.data);
				inl = divisor_ok(in_mon.data) && pair_dist <= inlier_thr;
				exp_t.pair_count = pairs_acc < MAX_PAIRS ? pairs_acc + 1'b1 : pairs_acc;
				exp_t.inlier_count = (inl && inliers_acc < MAX_PAIRS) ?
					inliers_acc + 1'b1 : inliers_acc;
				exp_t.truncated_cost = sum_sat(cost_acc, pair_dist > cap ? cap : pair_dist);
				exp_t.distance_sum = sum_sat(dist_acc, pair_dist);
				if (in_mon.data.last) begin
					few = exp_t.pair_count < 4;
					exp_t.too_few = few;
					exp_t.accepted = !few && (!check_on ||
						64'(exp_t.inlier_count) * 65536 >=
						64'(ratio) * 64'(exp_t.pair_count));
					totals_q = {totals_q, exp_t};
					pairs_acc <= '0;
					inliers_acc <= '0;
					cost_acc <= '0;
					dist_acc <= '0;
				end else begin
					pairs_acc <= exp_t.pair_count;
					inliers_acc <= exp_t.inlier_count;
					cost_acc <= exp_t.truncated_cost;
					dist_acc <= exp_t.distance_sum;
				end
			end
			// Compare each totals beat with the oldest prediction.
			if (out_mon.valid && out_mon.ready) begin
				got = out_mon.data;
				if (totals_q.size() == 0) begin
					$error("totals beat with no set pending");
					fail_count <= fail_count + 1;
				end else begin
					exp_t = totals_q.pop_front();
					if (got != exp_t) fail_count <= fail_count + 1;
					if (got.pair_count != exp_t.pair_count)
						$error("pair_count exp %0d got %0d", exp_t.pair_count, got.pair_count);
					if (got.inlier_count != exp_t.inlier_count)
						$error("inlier_count exp %0d got %0d",
							exp_t.inlier_count, got.inlier_count);
					if (got.truncated_cost != exp_t.truncated_cost)
						$error("truncated_cost exp %0d got %0d",
							exp_t.truncated_cost, got.truncated_cost);
					if (got.distance_sum != exp_t.distance_sum)
						$error("distance_sum exp %0d got %0d",
							exp_t.distance_sum, got.distance_sum);
					if (got.too_few != exp_t.too_few)
						$error("too_few exp %0d got %0d", exp_t.too_few, got.too_few);
					if (got.accepted != exp_t.accepted)
						$error("accepted exp %0d got %0d", exp_t.accepted, got.accepted);
				end
			end
		end
	end
endmodule

/* test/tb_top.sv */
// Testbench top for the homography reprojection scorer: clock, reset, register
// phases, pair stimulus with bursty sender and stalling receiver, and verdict.
// Depends on hrs_pkg, hrs_tb_pkg, hrs_if, hrs_scoreboard and the scorer top.
`timescale 1ns / 1ps
module tb_top;
	import hrs_pkg::*;
	import hrs_tb_pkg::*;

	typedef enum {PK_NEAR, PK_WILD} pair_kind_t;

	localparam int  RANDOM_ITEMS = 1600;
	localparam int  SETTLE       = 100;
	localparam longint LIMIT     = 3000000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;
	int                   fail_count, pending;
	longint               cycles;
	int                   burst_left;
	int                   items_sent;
	int                   shift_x, shift_y;

	hrs_if #(.T(pair_t))   in_if (clk);
	hrs_if #(.T(totals_t)) out_if (clk);

	homography_reprojection_scorer dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in(in_if), .out(out_if)
	);

	hrs_scoreboard chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_mon(in_if), .out_mon(out_if),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver ready follows four rotating patterns, one of them without stalls.
	always @(posedge clk) begin
		case ((cycles / 256) % 4)
			0: out_if.ready <= 1'b1;
			1: out_if.ready <= $urandom_range(1, 0);
			2: out_if.ready <= ($urandom_range(7, 0) == 0);
			default: out_if.ready <= (cycles % 16) >= 5;
		endcase
	end

	// Offer one pair and hold it until accepted; gaps fall between bursts.
	task automatic send_pair(input pair_t p);
		int gap;
		if (burst_left <= 0) begin
			gap = $urandom_range(8, 1);
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(3, 0) == 0) ? 200 : $urandom_range(12, 1);
		end
		in_if.valid <= 1'b1;
		in_if.data <= p;
		do @(posedge clk); while (!in_if.ready);
		burst_left--;
		items_sent++;
	endtask

	function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
		return COORD_BITS'(v < 0 ? 0 : (v > 16383 ? 16383 : v));
	endfunction

	function automatic pair_t make_pair(pair_kind_t kind);
		pair_t p;
		int noise;
		p.src_x = COORD_BITS'($urandom);
		p.src_y = COORD_BITS'($urandom);
		p.last = 1'b0;
		if (kind == PK_NEAR) begin
			noise = ($urandom_range(9, 0) == 0) ? 400 : 3;
			p.dst_x = clamp_coord(p.src_x + shift_x + $urandom_range(2 * noise, 0) - noise);
			p.dst_y = clamp_coord(p.src_y + shift_y + $urandom_range(2 * noise, 0) - noise);
		end else begin
			p.dst_x = COORD_BITS'($urandom);
			p.dst_y = COORD_BITS'($urandom);
		end
		return p;
	endfunction

	task automatic send_set(int n, pair_kind_t kind);
		pair_t p;
		for (int i = 0; i < n; i++) begin
			p = make_pair(kind);
			p.last = (i == n - 1);
			send_pair(p);
		end
	endtask

	// Wait until the block is idle: all totals back, then its latency.
	task automatic drain();
		in_if.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write all eight registers back to back.
	task automatic write_regs(input logic [CFG_W-1:0] v[8]);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= reg_idx_t'(i);
			cfg_data <= v[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [23:0] pick_thr();
		case ($urandom_range(3, 0))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			default: return 24'($urandom_range(2048, 64));
		endcase
	endfunction

	// Random register phase: near-identity, mild perspective or fully random.
	task automatic random_phase(output pair_kind_t kind);
		logic [CFG_W-1:0] v[8];
		logic [31:0] lin_a, lin_e;
		int sel;
		sel = $urandom_range(2, 0);
		shift_x = $urandom_range(40, 0) - 20;
		shift_y = $urandom_range(40, 0) - 20;
		lin_a = 32'h10000 + $urandom_range(64, 0) - 32;
		lin_e = 32'h10000 + $urandom_range(64, 0) - 32;
		kind = (sel == 2) ? PK_WILD : PK_NEAR;
		v[REG_ROW0] = {lin_a, 32'(signed'($urandom_range(16, 0) - 8))};
		v[REG_ROW1] = {32'(signed'($urandom_range(16, 0) - 8)), lin_e};
		v[REG_SHIFT] = {32'(shift_x * 65536 + $urandom_range(65535, 0)),
			32'(shift_y * 65536 + $urandom_range(65535, 0))};
		v[REG_PERSP] = (sel == 1) ?
			{32'(signed'($urandom_range(4000, 0) - 2000)),
			 32'(signed'($urandom_range(4000, 0) - 2000))} : 64'd0;
		if (sel == 2) begin
			v[REG_ROW0] = {$urandom, $urandom};
			v[REG_ROW1] = {$urandom, $urandom};
			v[REG_SHIFT] = {$urandom, $urandom};
			v[REG_PERSP] = ($urandom_range(1, 0) == 0) ? {$urandom, $urandom} :
				{32'($urandom_range(65535, 0)) - 32'd32768, 32'($urandom_range(65535, 0))};
		end
		v[REG_INLIER] = {$urandom, $urandom};
		v[REG_INLIER][23:0] = pick_thr();
		v[REG_CAP] = {$urandom, $urandom};
		v[REG_CAP][23:0] = pick_thr();
		v[REG_RATIO] = {$urandom, 15'd0, 17'd0};
		case ($urandom_range(4, 0))
			0: v[REG_RATIO][16:0] = 17'd0;
			1: v[REG_RATIO][16:0] = 17'd65536;
			2: v[REG_RATIO][16:0] = 17'h1FFFF;
			default: v[REG_RATIO][16:0] = 17'($urandom_range(65536, 0));
		endcase
		v[REG_CHECK] = {$urandom, $urandom};
		write_regs(v);
	endtask

	initial begin
		logic [CFG_W-1:0] v[8];
		pair_t p;
		pair_kind_t kind;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_if.valid = 1'b0;
		in_if.data = '0;
		out_if.ready = 1'b0;
		cycles = 0;
		burst_left = 0;
		items_sent = 0;
		shift_x = 0;
		shift_y = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers, identity: exact match, coordinate extremes,
		// sets of one, three and four pairs.
		p = '{src_x: 0, src_y: 0, dst_x: 0, dst_y: 0, last: 1'b1};
		send_pair(p);
		p = '{src_x: 14'h3FFF, src_y: 14'h3FFF, dst_x: 14'h3FFF, dst_y: 14'h3FFF, last: 0};
		send_pair(p);
		p = '{src_x: 14'h3FFF, src_y: 0, dst_x: 0, dst_y: 14'h3FFF, last: 0};
		send_pair(p);
		p = '{src_x: 100, src_y: 200, dst_x: 102, dst_y: 201, last: 1'b1};
		send_pair(p);
		p = '{src_x: 5, src_y: 7, dst_x: 8, dst_y: 7, last: 0};
		send_pair(p);
		p = '{src_x: 5, src_y: 7, dst_x: 5, dst_y: 10, last: 0};
		send_pair(p);
		p = '{src_x: 9000, src_y: 1, dst_x: 9000, dst_y: 1, last: 0};
		send_pair(p);
		p = '{src_x: 0, src_y: 14'h3FFF, dst_x: 14'h3FFF, dst_y: 0, last: 1'b1};
		send_pair(p);
		drain();

		// Coefficient extremes: non-positive divisor for x >= 1 and a clamped
		// projection at x = 0; widest inlier threshold, zero cost cap, ratio above one.
		v[REG_ROW0] = {32'h7FFFFFFF, 32'h80000000};
		v[REG_ROW1] = {32'h80000000, 32'h7FFFFFFF};
		v[REG_SHIFT] = '1;
		v[REG_PERSP] = {32'h80000000, 32'h0};
		v[REG_INLIER] = 64'hFFFFFF;
		v[REG_CAP] = 64'd0;
		v[REG_RATIO] = 64'h1FFFF;
		v[REG_CHECK] = 64'd1;
		write_regs(v);
		p = '{src_x: 0, src_y: 14'h3FFF, dst_x: 0, dst_y: 0, last: 0};
		send_pair(p);
		p = '{src_x: 0, src_y: 1, dst_x: 14'h3FFF, dst_y: 14'h3FFF, last: 0};
		send_pair(p);
		p = '{src_x: 1, src_y: 0, dst_x: 0, dst_y: 0, last: 0};
		send_pair(p);
		p = '{src_x: 14'h3FFF, src_y: 14'h3FFF, dst_x: 1, dst_y: 1, last: 0};
		send_pair(p);
		p = '{src_x: 0, src_y: 0, dst_x: 0, dst_y: 0, last: 1'b1};
		send_pair(p);
		drain();

		// Random phases, mostly small sets.
		while (items_sent < RANDOM_ITEMS) begin
			random_phase(kind);
			for (int s = 0; s < 14; s++)
				send_set(($urandom_range(4, 0) == 0) ? $urandom_range(40, 5) :
					$urandom_range(8, 1), kind);
			drain();
		end

		drain();
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

/* homography_reprojection_scorer.f */
design/hrs_pkg.sv
design/hrs_if.sv
design/hrs_queue.sv
design/hrs_project.sv
design/homography_reprojection_scorer.sv
test/hrs_tb_pkg.sv
test/hrs_scoreboard.sv
test/tb_top.sv
